// ----- hdl/mma_pkg.sv -----
package mma_pkg;

  // Field widths of the channels
  localparam int CH_W       = 4;
  localparam int SAMP_W     = 16;
  localparam int VAL_W      = SAMP_W - 1;
  localparam int AVG_W      = 15;
  localparam int OUT_FILL_W = 3;

  // Configuration of the filter
  localparam int CHANNELS = 16;
  localparam int WINDOW   = 5;

  // Derived sizes
  localparam int CH_N      = 1 << CH_W;
  localparam int SUM_W     = VAL_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
  localparam int FILL_W    = $clog2(WINDOW + 1);
  localparam int FILL_W1   = FILL_W + 1;
  localparam int FILL_N    = 1 << FILL_W;
  localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MEM_DEPTH = CH_N * WINDOW;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int RECIP_K   = SUM_W;
  localparam int RECIP_W   = RECIP_K + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int QD_W      = SUM_W + FILL_W;

  typedef logic [CH_W-1:0]          chan_t;
  typedef logic signed [SAMP_W-1:0] sample_t;
  typedef logic [AVG_W-1:0]         avg_t;
  typedef logic [OUT_FILL_W-1:0]    ofill_t;

  typedef logic [RECIP_W-1:0] recip_arr_t [FILL_N];

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic update;
    logic mul;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_blocked;
  } dp_stat_t;

  // floor(2^RECIP_K / d) for every possible fill count, by long division
  function automatic recip_arr_t build_recip();
    recip_arr_t           t;
    logic [RECIP_W-1:0]   num;
    logic [RECIP_W-1:0]   q;
    logic [FILL_W1-1:0]   rem;
    for (int d = 0; d < FILL_N; d++) begin
      num = RECIP_W'(1) << RECIP_K;
      q   = '0;
      rem = '0;
      if (d != 0) begin
        for (int b = RECIP_W - 1; b >= 0; b--) begin
          rem = {rem[FILL_W1-2:0], num[b]};
          if (rem >= FILL_W1'(d)) begin
            rem  = rem - FILL_W1'(d);
            q[b] = 1'b1;
          end
        end
      end
      t[d] = q;
    end
    return t;
  endfunction

  localparam recip_arr_t RECIP = build_recip();

endpackage

// ----- hdl/mma_if.sv -----
interface mma_in_if;
  logic               valid;
  logic               ready;
  mma_pkg::chan_t     channel;
  mma_pkg::sample_t   sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mma_out_if;
  logic             valid;
  logic             ready;
  mma_pkg::chan_t   channel_out;
  mma_pkg::avg_t    average;
  mma_pkg::ofill_t  fill;

  modport source (output valid, output channel_out, output average, output fill,
                  input ready);
  modport sink   (input valid, input channel_out, input average, input fill,
                  output ready);
endinterface

// ----- hdl/multichannel_moving_average_top.sv -----
// Multichannel boxcar moving average.
//
// in_chan carries a channel number and a signed 16-bit sample; a request is
// taken when valid and ready are both high. Negative samples count as zero.
// Each channel holds its last WINDOW samples, a fill count and a running sum.
// out_chan returns one result per request: the channel echoed, the truncated
// mean of the held samples and the number held.
//
// Requests are taken one at a time: ready returns only once the controller
// has gone through lookup and window read, read-modify-write of the channel
// state, reciprocal multiply, and quotient correction, which loads the result
// into the output register and waits while that register is still blocked.
//
// The output register lets a request be taken while the previous result
// waits; if the receiver still stalls when the next result is ready, the
// block holds it and ready stays low until the output register frees.
//
// Reset clears every channel's fill count, oldest slot and sum at once; the
// sample memory needs no clearing since a slot is read only after a write.
module multichannel_moving_average_top (
  input  logic       clk,
  input  logic       rst_n,
  mma_in_if.sink     in_chan,
  mma_out_if.source  out_chan
);
  import mma_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mma_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_channel      (in_chan.channel),
    .in_sample       (in_chan.sample),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_channel_out (out_chan.channel_out),
    .out_average     (out_chan.average),
    .out_fill        (out_chan.fill)
  );

endmodule

// ----- hdl/mma_ctrl.sv -----
module mma_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mma_pkg::dp_stat_t   stat,
  output mma_pkg::ctrl_cmd_t  cmd
);
  import mma_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_MUL,
    S_FIX
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   ready_r;

  always_comb begin
    cmd.accept = in_valid && ready_r;
    cmd.update = (state_r == S_UPDATE);
    cmd.mul    = (state_r == S_MUL);
    cmd.finish = (state_r == S_FIX) && !stat.out_blocked;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_UPDATE;
      end
      S_UPDATE: state_nxt = S_MUL;
      S_MUL:    state_nxt = S_FIX;
      S_FIX: begin
        // hold until the output register can take the result
        if (!stat.out_blocked) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = ready_r;

endmodule

// ----- hdl/mma_datapath.sv -----
module mma_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  mma_pkg::ctrl_cmd_t  cmd,
  output mma_pkg::dp_stat_t   stat,
  input  mma_pkg::chan_t      in_channel,
  input  mma_pkg::sample_t    in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output mma_pkg::chan_t      out_channel_out,
  output mma_pkg::avg_t       out_average,
  output mma_pkg::ofill_t     out_fill
);
  import mma_pkg::*;

  // Per-channel state
  logic [FILL_W-1:0] chan_fill_r [CH_N];
  logic [SLOT_W-1:0] chan_slot_r [CH_N];
  logic [SUM_W-1:0]  chan_sum_r  [CH_N];

  // Window sample memory
  logic [VAL_W-1:0]  mem [MEM_DEPTH];
  logic [VAL_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  // Request held across the update
  chan_t             ch_r;
  logic [VAL_W-1:0]  samp_r;
  logic              ok_r;
  logic              full_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SUM_W-1:0]  sum_r;
  logic [FILL_W-1:0] fill_r;

  // Division pipeline
  logic [SUM_W-1:0]  nsum_r;
  logic [FILL_W-1:0] nfill_r;
  logic [PROD_W-1:0] prod_r;

  // Output register
  logic              out_valid_r;
  chan_t             out_ch_r;
  avg_t              out_avg_r;
  ofill_t            out_fill_r;

  logic              in_ok;
  logic              in_full;
  logic [SLOT_W-1:0] in_slot;
  logic [VAL_W-1:0]  in_clamped;
  logic [SUM_W-1:0]  sum_nxt;
  logic [FILL_W-1:0] fill_nxt;
  logic [SLOT_W-1:0] slot_nxt;
  logic [SUM_W-1:0]  q_est;
  logic [QD_W-1:0]   qd;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  quot;

  // Accept: look up the channel and read the slot to be written (oldest once full)
  always_comb begin
    in_ok      = int'(in_channel) < CHANNELS;
    in_full    = (chan_fill_r[in_channel] == FILL_W'(WINDOW));
    in_slot    = in_full ? chan_slot_r[in_channel] : SLOT_W'(chan_fill_r[in_channel]);
    in_clamped = in_sample[SAMP_W-1] ? '0 : in_sample[VAL_W-1:0];
    rd_addr    = ADDR_W'(in_channel) * ADDR_W'(WINDOW) + ADDR_W'(in_slot);
    wr_addr    = ADDR_W'(ch_r) * ADDR_W'(WINDOW) + ADDR_W'(slot_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data_r <= mem[rd_addr];
      ch_r      <= in_channel;
      samp_r    <= in_clamped;
      ok_r      <= in_ok;
      full_r    <= in_full;
      slot_r    <= in_slot;
      sum_r     <= chan_sum_r[in_channel];
      fill_r    <= chan_fill_r[in_channel];
    end
    if (cmd.update && ok_r) begin
      mem[wr_addr] <= samp_r;
    end
  end

  // Update: drop the oldest sample when full, add the new one
  always_comb begin
    sum_nxt  = sum_r - (full_r ? SUM_W'(rd_data_r) : '0) + SUM_W'(samp_r);
    fill_nxt = full_r ? FILL_W'(WINDOW) : fill_r + FILL_W'(1);
    if (!full_r) begin
      slot_nxt = '0;
    end else if (slot_r == SLOT_W'(WINDOW - 1)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CH_N; i++) begin
        chan_fill_r[i] <= '0;
        chan_slot_r[i] <= '0;
        chan_sum_r[i]  <= '0;
      end
    end else if (cmd.update && ok_r) begin
      chan_fill_r[ch_r] <= fill_nxt;
      chan_slot_r[ch_r] <= slot_nxt;
      chan_sum_r[ch_r]  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      nsum_r  <= ok_r ? sum_nxt : '0;
      nfill_r <= ok_r ? fill_nxt : '0;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(nsum_r) * PROD_W'(RECIP[nfill_r]);
    end
  end

  // Reciprocal estimate is the quotient or one below it: correct once
  always_comb begin
    q_est = prod_r[RECIP_K +: SUM_W];
    qd    = QD_W'(q_est) * QD_W'(nfill_r);
    rem   = nsum_r - qd[SUM_W-1:0];
    quot  = (rem >= SUM_W'(nfill_r)) ? q_est + SUM_W'(1) : q_est;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ch_r   <= ch_r;
      out_avg_r  <= ok_r ? AVG_W'(quot) : '0;
      out_fill_r <= ok_r ? OUT_FILL_W'(nfill_r) : '0;
    end
  end

  assign stat.out_blocked = out_valid_r && !out_ready;
  assign out_valid        = out_valid_r;
  assign out_channel_out  = out_ch_r;
  assign out_average      = out_avg_r;
  assign out_fill         = out_fill_r;

endmodule

// ----- tb/sv/tb_multichannel_moving_average_top.sv -----
module tb_multichannel_moving_average_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mma_pkg::*;

  localparam int NUM_RANDOM   = 1830;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    chan_t   channel;
    avg_t    average;
    ofill_t  fill;
  } average_t;

  typedef struct {
    chan_t   channel;
    sample_t sample;
    bit      typed;
    avg_t    average;
    ofill_t  fill;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mma_in_if  in_if();
  mma_out_if out_if();

  multichannel_moving_average_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #5 clk = ~clk;

  // Own copy of each channel's window, fill count, oldest slot and sum
  logic [14:0] win_samples [CHANNELS][WINDOW];
  logic [2:0]  win_held    [CHANNELS];
  logic [2:0]  win_oldest  [CHANNELS];
  logic [17:0] win_sum     [CHANNELS];

  average_t pending_averages[$];
  int       fail_count = 0;
  bit       long_hold_req = 1'b0;

  // Fixed rows: extremes, negative clamping, window fill and wrap
  stim_row_t directed_rows [20] = '{
    '{4'd0,  16'sh7fff, 1'b1, 15'd32767, 3'd1},
    '{4'd1,  16'sh8000, 1'b1, 15'd0,     3'd1},
    '{4'd15, 16'shffff, 1'b1, 15'd0,     3'd1},
    '{4'd15, 16'sh0001, 1'b1, 15'd0,     3'd2},
    '{4'd2,  16'sh7fff, 1'b1, 15'd32767, 3'd1},
    '{4'd2,  16'sh7fff, 1'b1, 15'd32767, 3'd2},
    '{4'd2,  16'sh7fff, 1'b1, 15'd32767, 3'd3},
    '{4'd2,  16'sh7fff, 1'b1, 15'd32767, 3'd4},
    '{4'd2,  16'sh7fff, 1'b1, 15'd32767, 3'd5},
    '{4'd2,  16'sh7fff, 1'b1, 15'd32767, 3'd5},
    '{4'd2,  16'sh0000, 1'b0, 15'd0,     3'd0},
    '{4'd2,  16'shfffb, 1'b0, 15'd0,     3'd0},
    '{4'd2,  16'sh5555, 1'b0, 15'd0,     3'd0},
    '{4'd2,  16'sh2aaa, 1'b0, 15'd0,     3'd0},
    '{4'd2,  16'sh0003, 1'b0, 15'd0,     3'd0},
    '{4'd2,  16'sh0007, 1'b0, 15'd0,     3'd0},
    '{4'd10, 16'sh5555, 1'b0, 15'd0,     3'd0},
    '{4'd5,  16'sh2aaa, 1'b0, 15'd0,     3'd0},
    '{4'd0,  16'sh0000, 1'b0, 15'd0,     3'd0},
    '{4'd15, 16'sh7ffe, 1'b0, 15'd0,     3'd0}
  };

  // Update the channel window and return its new truncated mean
  function automatic average_t update_average(chan_t ch, sample_t smp);
    average_t    res;
    logic [14:0] val;
    logic [2:0]  slot;
    val = smp[15] ? 15'd0 : smp[14:0];
    if (win_held[ch] >= 3'(WINDOW)) begin
      slot = win_oldest[ch];
      win_sum[ch] = win_sum[ch] - 18'(win_samples[ch][slot]) + 18'(val);
      win_samples[ch][slot] = val;
      win_oldest[ch] = (slot == 3'(WINDOW - 1)) ? 3'd0 : slot + 3'd1;
    end else begin
      win_samples[ch][win_held[ch]] = val;
      win_sum[ch] = win_sum[ch] + 18'(val);
      win_held[ch] = win_held[ch] + 3'd1;
    end
    res.channel = ch;
    res.average = 15'(win_sum[ch] / 18'(win_held[ch]));
    res.fill    = win_held[ch];
    return res;
  endfunction

  task automatic offer_request(input chan_t ch, input sample_t smp, input bit typed,
                               input avg_t avg, input ofill_t fill);
    average_t res;
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.channel <= ch;
    in_if.sample  <= smp;
    do @(posedge clk); while (!in_if.ready);
    res = update_average(ch, smp);
    if (typed) begin
      res.average = avg;
      res.fill    = fill;
    end
    pending_averages.insert(pending_averages.size(), res);
  endtask

  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return -sample_t'($urandom_range(1, 40));
      3:       return sample_t'($urandom_range(0, 15));
      4:       return sample_t'($urandom_range(32000, 32767));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Receiver: stall pattern redrawn after each random span; long hold on request
  initial begin
    int mode;
    int hold_left;
    int span;
    out_if.ready = 1'b0;
    mode = 0;
    hold_left = 0;
    span = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req && hold_left == 0) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(16, 80);
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= ($urandom_range(0, 9) < 7);
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    average_t exp_res;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_averages.size() == 0) begin
        $display("%0t: unexpected result channel %0d average %0d fill %0d", $realtime,
                 out_if.channel_out, out_if.average, out_if.fill);
        fail_count++;
      end else begin
        exp_res = pending_averages.pop_front();
        if (out_if.channel_out !== exp_res.channel) begin
          $display("%0t: channel expected %0d actual %0d", $realtime,
                   exp_res.channel, out_if.channel_out);
          fail_count++;
        end
        if (out_if.average !== exp_res.average) begin
          $display("%0t: average expected %0d actual %0d", $realtime,
                   exp_res.average, out_if.average);
          fail_count++;
        end
        if (out_if.fill !== exp_res.fill) begin
          $display("%0t: fill expected %0d actual %0d", $realtime,
                   exp_res.fill, out_if.fill);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int    burst;
    int    sent;
    chan_t hot_ch;
    for (int c = 0; c < CHANNELS; c++) begin
      win_held[c]   = '0;
      win_oldest[c] = '0;
      win_sum[c]    = '0;
      for (int w = 0; w < WINDOW; w++) win_samples[c][w] = '0;
    end
    in_if.valid   = 1'b0;
    in_if.channel = '0;
    in_if.sample  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].channel, directed_rows[i].sample,
                    directed_rows[i].typed, directed_rows[i].average,
                    directed_rows[i].fill);
      if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 4));
    end

    sent = 0;
    hot_ch = chan_t'($urandom_range(0, 15));
    while (sent < NUM_RANDOM) begin
      // Ask for a long receiver stall if a burst starts at request 400 or 1300
      if (sent == 400 || sent == 1300) long_hold_req = 1'b1;
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < NUM_RANDOM; k++) begin
        if ($urandom_range(0, 3) == 0) hot_ch = chan_t'($urandom_range(0, 15));
        offer_request(($urandom_range(0, 2) == 0) ? chan_t'($urandom_range(0, 15)) : hot_ch,
                      pick_sample(), 1'b0, '0, '0);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
    end
    idle_sender(1);

    while (pending_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
